@@ src/stepper_microstep_sequencer_assert.svh @@
// Assertion macros shared by the checker of the stepper microstep sequencer.
// Depends on nothing; included by the checker module.
`ifndef STEPPER_MICROSTEP_SEQUENCER_ASSERT_SVH
`define STEPPER_MICROSTEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMS_AST_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SMS_AST_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SMS_AST_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ src/sms_pkg.sv @@
// Package of the stepper microstep sequencer: sizes, state encoding, motor record.
// Depends on nothing; imported by the top level and the checker.
package sms_pkg;

    localparam int MOTORS  = 4;
    localparam int STEPS   = 8;
    localparam int MAX_OUT = 4;
    localparam int ID_W    = 2;
    localparam int POS_W   = 3;
    localparam int TICK_W  = 32;
    localparam int DLY_W   = 16;
    localparam int LVL_W   = 8;
    localparam int CNT_W   = 3;
    localparam int DIV_W   = $clog2(TICK_W);
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLEEP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FULL_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_FULL_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLD_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD_B = 3'd5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [1:0] DIR_STOP = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_BWD  = 2'b11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_RD,
        S_SET_WR,
        S_TK_RD,
        S_TK_LD,
        S_TK_DIV,
        S_TK_WR
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [TICK_W-1:0] tick;
        logic [DLY_W-1:0]  dly;
        logic [1:0]        head;
        logic [LVL_W-1:0]  lvl_a;
        logic [LVL_W-1:0]  lvl_b;
    } t_motor;

    localparam t_motor MOTOR_RESET = '{pos: '0, tick: '0, dly: DLY_W'(1),
                                       head: DIR_STOP, lvl_a: '0, lvl_b: '0};

endpackage

@@ src/stepper_microstep_sequencer.sv @@
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_command, i_motor_sel, i_step_delay, i_step_dir
// output    o_valid   i_stall   o_motor_id .. o_last (one transaction per active motor of a tick)
//
// A set transaction passes through the idle state in which it is accepted, a memory
// read and the write-back of the motor record.
// A tick, after the idle state in which it is accepted, takes each active motor through
// a memory read, a load, the bit-serial remainder unit that computes the incremented
// tick mod delay, and a write-back, which waits while the output register holds a stalled result.
// Reset is synchronous and clears control state and the record valid bits;
// a motor whose record was never written reads its reset values.
// Input is accepted only in the idle state; the output register lets the
// next transaction start while the last result still waits to be taken.
//
// Depends on sms_pkg.
module stepper_microstep_sequencer
    import sms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [ID_W-1:0]      i_motor_sel,
    input  logic [DLY_W-1:0]     i_step_delay,
    input  logic signed [1:0]    i_step_dir,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ID_W-1:0]      o_motor_id,
    output logic [POS_W-1:0]     o_step_index,
    output logic [6:0]           o_a_pos_duty,
    output logic [7:0]           o_a_neg_duty,
    output logic [6:0]           o_b_pos_duty,
    output logic [7:0]           o_b_neg_duty,
    output logic                 o_stepped,
    output logic [TICK_W-1:0]    o_total_steps,
    output logic                 o_last
);

    // Configuration registers.
    logic [CNT_W-1:0] r_active;
    logic [DLY_W-1:0] r_sleep;
    logic [CFG_W-1:0] r_full_a, r_full_b, r_hold_a, r_hold_b;

    // Motor record memory with one valid bit per entry.
    t_motor           r_mem [MOTORS];
    logic [MOTORS-1:0] r_vld;
    t_motor           r_rd;
    logic             r_rd_vld;
    logic [ID_W-1:0]  rd_addr;
    logic             mem_we;
    logic [ID_W-1:0]  wr_addr;
    t_motor           wr_data;

    t_state r_state, n_state;

    // Captured transaction and walk control.
    logic [ID_W-1:0]   r_sel;
    logic [DLY_W-1:0]  r_sdly;
    logic [1:0]        r_sdir;
    logic [ID_W-1:0]   r_m;
    logic [ID_W-1:0]   r_lastm;
    logic [TICK_W-1:0] r_total;

    // Working record and remainder unit.
    t_motor            r_ent;
    logic [TICK_W-1:0] r_sh;
    logic [DLY_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dcnt;

    logic [CNT_W-1:0]  count;
    logic              in_acc;
    logic              out_free;
    t_motor            rd_eff;
    logic [DLY_W-1:0]  dly;
    logic [DLY_W:0]    rem2;
    logic [DLY_W-1:0]  n_rem;

    // Tick update values for the write-back cycle.
    logic              stepped;
    logic [POS_W-1:0]  new_pos;
    logic [TICK_W-1:0] new_tick;
    logic [LVL_W-1:0]  new_a, new_b;
    logic [TICK_W-1:0] new_total;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign count    = (r_active > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : r_active;
    assign rd_eff   = r_rd_vld ? r_rd : MOTOR_RESET;
    assign dly      = (r_ent.dly == '0) ? DLY_W'(1) : r_ent.dly;
    assign rem2     = {r_rem, r_sh[TICK_W-1]};
    assign n_rem    = (rem2 >= {1'b0, dly}) ? DLY_W'(rem2 - {1'b0, dly}) : rem2[DLY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_sleep  <= DLY_W'(1000);
            r_full_a <= '0;
            r_full_b <= '0;
            r_hold_a <= '0;
            r_hold_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACTIVE: r_active <= i_cfg_data[CNT_W-1:0];
                REG_SLEEP:  r_sleep  <= i_cfg_data[DLY_W-1:0];
                REG_FULL_A: r_full_a <= i_cfg_data;
                REG_FULL_B: r_full_b <= i_cfg_data;
                REG_HOLD_A: r_hold_a <= i_cfg_data;
                REG_HOLD_B: r_hold_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Synchronous memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd     <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_SET) begin
                        n_state = S_SET_RD;
                    end else if (count != '0) begin
                        n_state = S_TK_RD;
                    end
                end
            end
            S_SET_RD: n_state = S_SET_WR;
            S_SET_WR: n_state = S_IDLE;
            S_TK_RD:  n_state = S_TK_LD;
            S_TK_LD:  n_state = S_TK_DIV;
            S_TK_DIV: begin
                if (r_dcnt == DIV_W'(TICK_W - 1)) begin
                    n_state = S_TK_WR;
                end
            end
            S_TK_WR: begin
                if (out_free) begin
                    n_state = (r_m == r_lastm) ? S_IDLE : S_TK_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Step rule, evaluated on the working record.
    always_comb begin
        stepped   = (r_rem == '0) && (r_ent.head != DIR_STOP);
        new_pos   = r_ent.pos;
        new_tick  = r_sh;
        new_a     = r_ent.lvl_a;
        new_b     = r_ent.lvl_b;
        new_total = r_total;
        if (stepped) begin
            if (r_ent.head == DIR_FWD) begin
                new_pos = (r_ent.pos == POS_W'(STEPS - 1)) ? '0 : r_ent.pos + 1'b1;
            end else begin
                new_pos = (r_ent.pos == '0) ? POS_W'(STEPS - 1) : r_ent.pos - 1'b1;
            end
            new_tick  = '0;
            new_a     = r_full_a[{new_pos, 3'b000} +: LVL_W];
            new_b     = r_full_b[{new_pos, 3'b000} +: LVL_W];
            new_total = r_total + 1'b1;
        end
        if (new_tick == {{(TICK_W-DLY_W){1'b0}}, r_sleep}) begin
            new_a = r_hold_a[{new_pos, 3'b000} +: LVL_W];
            new_b = r_hold_b[{new_pos, 3'b000} +: LVL_W];
        end
    end

    // Output logic of the state machine.
    always_comb begin
        o_stall = 1'b1;
        mem_we  = 1'b0;
        wr_addr = r_m;
        wr_data = r_ent;
        rd_addr = r_m;
        unique case (r_state)
            S_IDLE:   o_stall = 1'b0;
            S_SET_RD: rd_addr = r_sel;
            S_SET_WR: begin
                mem_we       = 1'b1;
                wr_addr      = r_sel;
                wr_data      = rd_eff;
                wr_data.dly  = r_sdly;
                wr_data.head = r_sdir;
            end
            S_TK_WR: begin
                mem_we        = out_free;
                wr_data.pos   = new_pos;
                wr_data.tick  = new_tick;
                wr_data.lvl_a = new_a;
                wr_data.lvl_b = new_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_m <= '0;
            end else if (r_state == S_TK_WR && out_free) begin
                r_total <= new_total;
                r_m     <= r_m + 1'b1;
            end
        end
    end

    // Payload capture and the remainder unit, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_sel   <= i_motor_sel;
            r_sdly  <= i_step_delay;
            r_sdir  <= (i_step_dir == 2'sb00) ? DIR_STOP :
                       (i_step_dir == 2'sb01) ? DIR_FWD : DIR_BWD;
            r_lastm <= ID_W'(count - 1'b1);
        end
        if (r_state == S_TK_LD) begin
            r_ent  <= rd_eff;
            r_sh   <= rd_eff.tick + 1'b1;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (r_state == S_TK_DIV) begin
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + 1'b1;
            // The dividend rotates through, so the incremented count is back
            // in place when the last bit is consumed.
            r_sh   <= {r_sh[TICK_W-2:0], r_sh[TICK_W-1]};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_TK_WR && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TK_WR && out_free) begin
            o_motor_id    <= r_m;
            o_step_index  <= new_pos;
            o_a_pos_duty  <= new_a[LVL_W-1] ? '0 : new_a[6:0];
            o_a_neg_duty  <= new_a[LVL_W-1] ? 8'(-new_a) : '0;
            o_b_pos_duty  <= new_b[LVL_W-1] ? '0 : new_b[6:0];
            o_b_neg_duty  <= new_b[LVL_W-1] ? 8'(-new_b) : '0;
            o_stepped     <= stepped;
            o_total_steps <= new_total;
            o_last        <= (r_m == r_lastm);
        end
    end

endmodule

@@ src/sms_checker.sv @@
// Port-level checker for the stepper microstep sequencer, bound to the top level.
// Depends on sms_pkg and stepper_microstep_sequencer_assert.svh.
`include "stepper_microstep_sequencer_assert.svh"
module sms_checker
    import sms_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_command,
    input logic               o_valid,
    input logic               i_stall,
    input logic [6:0]         o_a_pos_duty,
    input logic [7:0]         o_a_neg_duty,
    input logic [TICK_W-1:0]  o_total_steps
);

    // A stalled result holds.
    `SMS_AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_total_steps))
    // An accepted set transaction keeps the block busy in the next cycle.
    `SMS_AST_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall && i_command == CMD_SET, o_stall)
    // At most one side of coil A is driven while a result is valid.
    `SMS_AST_NOW(a_coil, i_clk, i_rst_n, o_valid, o_a_pos_duty == '0 || o_a_neg_duty == '0)
    // Reset empties the output register.
    `SMS_AST_ALWAYS(a_rst, i_clk, !i_rst_n, !o_valid)

endmodule

bind stepper_microstep_sequencer sms_checker u_sms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_a_pos_duty  (o_a_pos_duty),
    .o_a_neg_duty  (o_a_neg_duty),
    .o_total_steps (o_total_steps)
);
